/* rtl/ffca_pkg.sv */
// Shared constants, types and status codes of the first-fit chunk allocator.
package ffca_pkg;

  localparam int MAX_CHUNKS = 64;
  localparam int ADDR_W     = 20;
  localparam int AMT_W      = ADDR_W + 1;
  localparam int END_W      = ADDR_W + 2;

  // size of the granule address space
  localparam logic [END_W-1:0] ADDR_SPAN = END_W'(1) << ADDR_W;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_ALLOC  = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOFIT   = 2'd1;
  localparam status_t ST_CORRUPT = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  typedef logic [MAX_CHUNKS-1:0] chunk_vec_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              eval;
    logic              apply;
    logic              alloc;
    logic              high;
    logic [AMT_W-1:0]  amount;
    logic [ADDR_W-1:0] base;
  } cell_ctl_t;

endpackage

/* rtl/ffca_cell.sv */
// One table cell: holds one free chunk, flags a fit and takes its right neighbor on removal.
module ffca_cell import ffca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              pick,
  input  logic              shift,
  input  logic              wr,
  input  logic              nb_valid,
  input  logic [ADDR_W-1:0] nb_start,
  input  logic [AMT_W-1:0]  nb_size,
  output logic              valid,
  output logic [ADDR_W-1:0] start,
  output logic [AMT_W-1:0]  size,
  output logic              fit,
  output logic              eq,
  output logic [AMT_W-1:0]  last_end,
  output logic [ADDR_W-1:0] grant
);

  logic              valid_r, valid_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [AMT_W-1:0]  size_r, size_nxt;
  logic              fit_r, eq_r;
  logic [END_W-1:0]  top_addr;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    valid_nxt = valid_r;
    start_nxt = start_r;
    size_nxt  = size_r;
    if (ctl.apply) begin
      if (wr) begin
        valid_nxt = 1'b1;
        start_nxt = ctl.base;
        size_nxt  = ctl.amount;
      end else if (shift) begin
        // close the gap left by a removed chunk
        valid_nxt = nb_valid;
        start_nxt = nb_start;
        size_nxt  = nb_size;
      end else if (pick) begin
        size_nxt = size_r - ctl.amount;
        if (!ctl.high) begin
          start_nxt = ADDR_W'({1'b0, start_r} + ctl.amount);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    size_r  <= size_nxt;
    if (ctl.eval) begin
      fit_r <= valid_r && (size_r >= ctl.amount);
      eq_r  <= valid_r && (size_r == ctl.amount);
    end
  end

  assign top_addr = ({2'b00, start_r} + {1'b0, size_r}) - {1'b0, ctl.amount};
  assign addr     = ctl.high ? top_addr[ADDR_W-1:0] : start_r;

  assign valid    = valid_r;
  assign start    = start_r;
  assign size     = size_r;
  assign fit      = fit_r;
  assign eq       = eq_r;
  assign last_end = (valid_r && !nb_valid) ? ({1'b0, start_r} + size_r) : '0;
  assign grant    = pick ? addr : '0;

endmodule

/* rtl/ffca_pick.sv */
// Chunk selector: isolates the first (or last) fitting cell and marks the cells from it upward.
module ffca_pick import ffca_pkg::*; (
  input  chunk_vec_t fit,
  input  logic       high,
  output chunk_vec_t onehot,
  output chunk_vec_t from_pick,
  output logic       none
);

  chunk_vec_t src, low_bit, rev_bit;

  // reverse mode: mirror the vector so the lowest set bit is the last fit
  always_comb begin
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      src[i] = high ? fit[MAX_CHUNKS-1-i] : fit[i];
    end
    low_bit = src & (~src + chunk_vec_t'(1));
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      rev_bit[i] = low_bit[MAX_CHUNKS-1-i];
    end
    onehot    = high ? rev_bit : low_bit;
    from_pick = ~(onehot - chunk_vec_t'(1));
    none      = ~|fit;
  end

endmodule

/* rtl/first_fit_chunk_allocator_top.sv */
// Top level of the first-fit chunk allocator: control, cell row and result register.
// Each request passes the fit, pick and apply states before its result turns valid.
// A new request is taken only once the previous one has applied; the apply step waits
// while the result register still holds an untaken result.
// Each cell compares its chunk in parallel; removal shifts the row down by one cell.
// Reset (rst_n low, synchronous) empties the table, clears the free count and the result valid flag.
module first_fit_chunk_allocator_top import ffca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [ADDR_W-1:0] in_chunk_base,
  input  logic [AMT_W-1:0]  in_amount,
  input  logic              in_take_high,
  output logic              out_valid,
  input  logic              out_ready,
  output status_t           out_status,
  output logic [ADDR_W-1:0] out_granted_address,
  output logic [AMT_W-1:0]  out_free_total
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIT   = 4'b0010,
    S_PICK  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic              op_r, high_r;
  logic [ADDR_W-1:0] base_r;
  logic [AMT_W-1:0]  amount_r;

  logic [AMT_W-1:0]  prev_end_r;
  logic              any_r, full_r;
  chunk_vec_t        pick_r, from_pick_r, wr_r;
  status_t           status_r;
  logic [AMT_W-1:0]  free_r, free_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [AMT_W-1:0]  out_free_r;

  cell_ctl_t         ctl;
  chunk_vec_t        c_valid, c_fit, c_eq, c_shift, first_free;
  logic [ADDR_W-1:0] c_start [MAX_CHUNKS];
  logic [AMT_W-1:0]  c_size  [MAX_CHUNKS];
  logic [AMT_W-1:0]  c_end   [MAX_CHUNKS];
  logic [ADDR_W-1:0] c_grant [MAX_CHUNKS];

  chunk_vec_t        sel_onehot, sel_from;
  logic              sel_none;
  logic              apply_go, exact;
  logic [AMT_W-1:0]  end_or;
  logic [ADDR_W-1:0] grant_or;
  logic [END_W-1:0]  new_end;
  status_t           app_status;

  assign in_ready = (state_r == S_IDLE);
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  assign ctl.eval   = (state_r == S_FIT);
  assign ctl.apply  = apply_go && (status_r == ST_OK);
  assign ctl.alloc  = (op_r == OP_ALLOC);
  assign ctl.high   = high_r;
  assign ctl.amount = amount_r;
  assign ctl.base   = base_r;

  assign exact   = |(pick_r & c_eq);
  assign c_shift = (ctl.alloc && exact) ? from_pick_r : '0;

  genvar g;
  generate
    for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
      logic              nb_valid;
      logic [ADDR_W-1:0] nb_start;
      logic [AMT_W-1:0]  nb_size;
      if (g < MAX_CHUNKS - 1) begin : g_nb
        assign nb_valid = c_valid[g+1];
        assign nb_start = c_start[g+1];
        assign nb_size  = c_size[g+1];
      end else begin : g_end
        assign nb_valid = 1'b0;
        assign nb_start = '0;
        assign nb_size  = '0;
      end
      if (g == 0) begin : g_ff0
        assign first_free[g] = !c_valid[g];
      end else begin : g_ffn
        assign first_free[g] = !c_valid[g] && c_valid[g-1];
      end

      ffca_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .pick     (ctl.alloc && pick_r[g]),
        .shift    (c_shift[g]),
        .wr       (!ctl.alloc && wr_r[g]),
        .nb_valid (nb_valid),
        .nb_start (nb_start),
        .nb_size  (nb_size),
        .valid    (c_valid[g]),
        .start    (c_start[g]),
        .size     (c_size[g]),
        .fit      (c_fit[g]),
        .eq       (c_eq[g]),
        .last_end (c_end[g]),
        .grant    (c_grant[g])
      );
    end
  endgenerate

  ffca_pick u_pick (
    .fit       (c_fit),
    .high      (high_r),
    .onehot    (sel_onehot),
    .from_pick (sel_from),
    .none      (sel_none)
  );

  // at most one cell drives a nonzero value, so an OR merges them
  always_comb begin
    end_or   = '0;
    grant_or = '0;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      end_or   = end_or | c_end[i];
      grant_or = grant_or | c_grant[i];
    end
  end

  assign new_end = {2'b00, base_r} + {1'b0, amount_r};

  always_comb begin
    if (full_r) begin
      app_status = ST_FULL;
    end else if (new_end > ADDR_SPAN) begin
      app_status = ST_CORRUPT;
    end else if (any_r && ({1'b0, base_r} <= prev_end_r)) begin
      app_status = ST_CORRUPT;
    end else begin
      app_status = ST_OK;
    end
  end

  always_comb begin
    free_nxt = free_r;
    if (ctl.apply) begin
      free_nxt = ctl.alloc ? (free_r - amount_r) : (free_r + amount_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_FIT;
      S_FIT:   state_nxt = S_PICK;
      S_PICK:  state_nxt = S_APPLY;
      S_APPLY: if (apply_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_opcode;
      high_r   <= in_take_high;
      base_r   <= in_chunk_base;
      amount_r <= in_amount;
    end
    if (state_r == S_FIT) begin
      prev_end_r <= end_or;
      any_r      <= c_valid[0];
      full_r     <= c_valid[MAX_CHUNKS-1];
    end
    if (state_r == S_PICK) begin
      pick_r      <= sel_onehot;
      from_pick_r <= sel_from;
      wr_r        <= first_free;
      if (op_r == OP_ALLOC) begin
        status_r <= sel_none ? ST_NOFIT : ST_OK;
      end else begin
        status_r <= app_status;
      end
    end
    if (apply_go) begin
      out_status_r <= status_r;
      out_addr_r   <= (ctl.alloc && status_r == ST_OK) ? grant_or : '0;
      out_free_r   <= free_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_free_total      = out_free_r;

endmodule
